@@ rtl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Request and status codes, entry layout and sequencer states shared by the
// double-ended queue and its entry store.
// ----------------------------------------------------------------------------
package deq_pkg;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  // One task descriptor: code handle and argument word.
  typedef struct packed {
    logic [31:0] arg;
    logic [31:0] code;
  } entry_t;

endpackage

@@ rtl/deq_store.sv @@
// ----------------------------------------------------------------------------
// deq_store
// Entry store of the queue: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module deq_store #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IW-1:0]   waddr_i,
  input  deq_pkg::entry_t wdata_i,
  input  logic            re_i,
  input  logic [IW-1:0]   raddr_i,
  output deq_pkg::entry_t rdata_o
);
  import deq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/double_ended_queue_top.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of task descriptors held in a ring of DEPTH
// entries in a synchronous store. Each item pushes at either end, pops from
// either end or peeks at either end, and returns one result carrying the
// status, the entry read (zero where none is read), the entry count and an
// empty flag. In the cycle an item is accepted the end pointers and the
// count are updated and the store is written or read; in the next the
// registered read data of the store is loaded into the result register.
// A new item is taken once the sequencer is idle and the result register
// is empty or being emptied. Pushes on a full queue, pops or peeks on an
// empty one and unused request codes leave the queue unchanged. Store
// contents need no clearing: the count guards every read.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
  parameter int DEPTH = 16,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [2:0]    req_type_i,
  input  logic [31:0]   task_code_i,
  input  logic [31:0]   task_arg_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    status_o,
  output logic [31:0]   out_code_o,
  output logic [31:0]   out_arg_o,
  output logic [CW-1:0] entry_count_o,
  output logic          empty_flag_o
);
  import deq_pkg::*;

  localparam logic [IW-1:0] LastIdx = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  state_e state_q, state_d;

  logic [IW-1:0] front_q, front_d;
  logic [IW-1:0] back_q, back_d;
  logic [CW-1:0] count_q, count_d;

  // Item waiting for the store's read data
  status_e       pend_status_q, pend_status_d;
  logic          pend_rd_q, pend_rd_d;
  logic [CW-1:0] pend_count_q, pend_count_d;

  // Result register
  logic          out_valid_q, out_valid_d;
  status_e       out_status_q;
  entry_t        out_entry_q;
  logic [CW-1:0] out_count_q;

  logic          accept;
  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  logic [IW-1:0] front_next, front_prev, back_next, back_prev;
  logic          is_empty, is_full;

  assign front_next = (front_q == LastIdx) ? '0 : front_q + 1'b1;
  assign front_prev = (front_q == '0) ? LastIdx : front_q - 1'b1;
  assign back_next  = (back_q == LastIdx) ? '0 : back_q + 1'b1;
  assign back_prev  = (back_q == '0) ? LastIdx : back_q - 1'b1;
  assign is_empty   = (count_q == '0);
  assign is_full    = (count_q == FullCnt);

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign wdata      = '{arg: task_arg_i, code: task_code_i};

  always_comb begin
    state_d       = state_q;
    front_d       = front_q;
    back_d        = back_q;
    count_d       = count_q;
    pend_status_d = pend_status_q;
    pend_rd_d     = pend_rd_q;
    pend_count_d  = pend_count_q;
    we            = 1'b0;
    re            = 1'b0;
    waddr         = back_q;
    raddr         = front_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          pend_status_d = STAT_OK;
          pend_rd_d     = 1'b0;
          case (req_type_i)
            REQ_PUSH_FRONT: begin
              if (is_full) begin
                pend_status_d = STAT_FULL;
              end else begin
                we      = 1'b1;
                waddr   = front_prev;
                front_d = front_prev;
                count_d = count_q + 1'b1;
              end
            end
            REQ_PUSH_BACK: begin
              if (is_full) begin
                pend_status_d = STAT_FULL;
              end else begin
                we      = 1'b1;
                waddr   = back_q;
                back_d  = back_next;
                count_d = count_q + 1'b1;
              end
            end
            REQ_POP_FRONT, REQ_PEEK_FRONT: begin
              if (is_empty) begin
                pend_status_d = STAT_EMPTY;
              end else begin
                re        = 1'b1;
                raddr     = front_q;
                pend_rd_d = 1'b1;
                if (req_type_i == REQ_POP_FRONT) begin
                  front_d = front_next;
                  count_d = count_q - 1'b1;
                end
              end
            end
            REQ_POP_BACK, REQ_PEEK_BACK: begin
              if (is_empty) begin
                pend_status_d = STAT_EMPTY;
              end else begin
                re        = 1'b1;
                raddr     = back_prev;
                pend_rd_d = 1'b1;
                if (req_type_i == REQ_POP_BACK) begin
                  back_d  = back_prev;
                  count_d = count_q - 1'b1;
                end
              end
            end
            default: begin
              // unused request codes: no effect
            end
          endcase
          pend_count_d = count_d;
          state_d      = S_READ;
        end
      end
      S_READ: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      back_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_status_q <= pend_status_d;
    pend_rd_q     <= pend_rd_d;
    pend_count_q  <= pend_count_d;
  end

  deq_store #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Load the result once the read data is out; drop it when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == S_READ) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      out_status_q <= pend_status_q;
      out_entry_q  <= pend_rd_q ? rdata : '0;
      out_count_q  <= pend_count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign out_code_o    = out_entry_q.code;
  assign out_arg_o     = out_entry_q.arg;
  assign entry_count_o = out_count_q;
  assign empty_flag_o  = (out_count_q == '0);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("held count exceeds depth");

  a_ends_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == FullCnt) |-> front_q == back_q)
    else $error("end pointers disagree with count");

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_READ && !out_valid_q)
    else $error("item accepted while a result was pending");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |=> out_valid_q && out_count_q == $past(count_q))
    else $error("result not loaded after read");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && re))
    else $error("store written and read by one item");
`endif

endmodule

@@ tb/double_ended_queue_top_tb.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_top_tb
// Drives push, pop and peek requests into the double-ended queue through its
// valid/ready ports and checks every result against a shadow deque kept in
// the testbench. A directed opening covers the empty, full and unused-code
// cases; random phases then lean towards filling, draining or holding the
// queue level, with random gaps on both ports.
// ----------------------------------------------------------------------------
module double_ended_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int          QUEUE_DEPTH  = 16;
  localparam int          CW           = $clog2(QUEUE_DEPTH + 1);
  localparam int          RANDOM_ITEMS = 1450;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam logic [2:0]  REQ_SPARE_6  = 3'd6;
  localparam logic [2:0]  REQ_SPARE_7  = 3'd7;

  typedef enum int { LEAN_FILL, LEAN_DRAIN, LEAN_EVEN } lean_e;

  typedef struct packed {
    status_e       status;
    logic [31:0]   code;
    logic [31:0]   arg;
    logic [CW-1:0] count;
    logic          empty;
  } deq_result_t;

  // Shadow deque: predicts each result at the moment its item is accepted.
  class deque_shadow;
    entry_t      ring [QUEUE_DEPTH];
    int unsigned front_slot;
    int unsigned back_slot;
    int unsigned held;
    deq_result_t awaited_results [$];
    int unsigned mismatches;

    function new();
      front_slot = 0;
      back_slot  = 0;
      held       = 0;
      mismatches = 0;
    endfunction

    function void note_request(logic [2:0] req, logic [31:0] code, logic [31:0] arg);
      deq_result_t want;
      int unsigned slot;
      want        = '0;
      want.status = STAT_OK;
      case (req)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (held == QUEUE_DEPTH) begin
            want.status = STAT_FULL;
          end else if (req == REQ_PUSH_FRONT) begin
            front_slot = (front_slot + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
            ring[front_slot] = '{arg: arg, code: code};
            held++;
          end else begin
            ring[back_slot] = '{arg: arg, code: code};
            back_slot = (back_slot + 1) % QUEUE_DEPTH;
            held++;
          end
        end
        REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
          if (held == 0) begin
            want.status = STAT_EMPTY;
          end else begin
            if (req == REQ_POP_FRONT || req == REQ_PEEK_FRONT)
              slot = front_slot;
            else
              slot = (back_slot + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
            want.code = ring[slot].code;
            want.arg  = ring[slot].arg;
            if (req == REQ_POP_FRONT) begin
              front_slot = (front_slot + 1) % QUEUE_DEPTH;
              held--;
            end else if (req == REQ_POP_BACK) begin
              back_slot = slot;
              held--;
            end
          end
        end
        default: ;  // spare codes leave the queue alone
      endcase
      want.count = held[CW-1:0];
      want.empty = (held == 0);
      awaited_results.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(deq_result_t got);
      deq_result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got status %0d count %0d",
                 $time, got.status, got.count);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("out_code", want.code, got.code);
      compare_field("out_arg", want.arg, got.arg);
      compare_field("entry_count", 32'(want.count), 32'(got.count));
      compare_field("empty_flag", 32'(want.empty), 32'(got.empty));
    endfunction

    function int unsigned outstanding();
      return awaited_results.size();
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  logic [2:0]    req_type_i;
  logic [31:0]   task_code_i;
  logic [31:0]   task_arg_i;
  logic          out_valid_o;
  logic          out_ready_i;
  logic [1:0]    status_o;
  logic [31:0]   out_code_o;
  logic [31:0]   out_arg_o;
  logic [CW-1:0] entry_count_o;
  logic          empty_flag_o;

  deque_shadow shadow = new();
  bit          calm;
  int unsigned cycle_count;

  double_ended_queue_top #(.DEPTH(QUEUE_DEPTH)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .task_code_i   (task_code_i),
    .task_arg_i    (task_arg_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .out_code_o    (out_code_o),
    .out_arg_o     (out_arg_o),
    .entry_count_o (entry_count_o),
    .empty_flag_o  (empty_flag_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one; none during calm phases.
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [31:0] pick_word();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 32'h0;
    if (roll == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic send_item(input logic [2:0] req, input logic [31:0] code,
                           input logic [31:0] arg);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    task_code_i <= code;
    task_arg_i  <= arg;
    do @(posedge clk_i); while (!in_ready_o);
    shadow.note_request(req, code, arg);
  endtask

  task automatic wait_drained();
    // Drop valid so the item just taken is not offered again.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (shadow.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input lean_e lean, input int len, inout int counted);
    int          push_pct;
    int          roll;
    logic [2:0]  req;
    push_pct = (lean == LEAN_FILL) ? 75 : (lean == LEAN_DRAIN) ? 25 : 50;
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        req = $urandom_range(0, 1) ? REQ_SPARE_7 : REQ_SPARE_6;
      end else begin
        if ($urandom_range(0, 99) < push_pct)
          req = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        else
          req = 3'($urandom_range(REQ_POP_FRONT, REQ_PEEK_BACK));
        counted++;
      end
      send_item(req, pick_word(), pick_word());
    end
  endtask

  // Result side: random stalls on out_ready_i, check on every handshake.
  initial begin
    int          stall_left;
    deq_result_t got;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = pick_gap();
      end
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.status = status_e'(status_o);
        got.code   = out_code_o;
        got.arg    = out_arg_o;
        got.count  = entry_count_o;
        got.empty  = empty_flag_o;
        shadow.check_result(got);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int    counted;
    lean_e lean;
    counted     = 0;
    calm        = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_PUSH_FRONT;
    task_code_i = '0;
    task_arg_i  = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty queue, spare codes, extreme words at both ends.
    send_item(REQ_POP_FRONT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(REQ_PEEK_BACK, 32'h0, 32'h0);
    send_item(REQ_SPARE_6, 32'hFFFF_FFFF, 32'h0);
    send_item(REQ_SPARE_7, 32'h0, 32'hFFFF_FFFF);
    send_item(REQ_PUSH_FRONT, 32'h0, 32'hFFFF_FFFF);
    send_item(REQ_PUSH_BACK, 32'hFFFF_FFFF, 32'h0);
    send_item(REQ_PEEK_FRONT, 32'h0, 32'h0);
    send_item(REQ_PEEK_BACK, 32'h0, 32'h0);
    send_item(REQ_POP_BACK, 32'h0, 32'h0);
    send_item(REQ_POP_FRONT, 32'h0, 32'h0);
    // Fill from both ends, then push once more into the full queue.
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_item(i[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT, $urandom, $urandom);
    send_item(REQ_PUSH_FRONT, $urandom, $urandom);

    for (int phase = 0; counted < RANDOM_ITEMS; phase++) begin
      lean = lean_e'($urandom_range(LEAN_FILL, LEAN_EVEN));
      calm = ($urandom_range(0, 4) == 0);
      run_phase(lean, $urandom_range(20, 60), counted);
      if (phase % 5 == 4) begin
        wait_drained();
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
